@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assertion failed");

`endif

@@ hdl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Word types, opcode and status codes, and pipeline types of the unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    // Width of one Q-format field on the ports.
    localparam int WORD_W    = 32;
    // Quotient bits produced by the divider, one per stage.
    localparam int DIV_STEPS = 32;
    // Width of a full product and of a divider denominator.
    localparam int PROD_W    = 64;

    // Opcodes.
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_DIV    = 3'd3;
    localparam logic [2:0] OP_REM    = 3'd4;
    localparam logic [2:0] OP_NEG    = 3'd5;
    localparam logic [2:0] OP_CMP    = 3'd6;
    // Spare code, treated like a compare.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Status codes.
    localparam logic [1:0] ST_EXACT = 2'd0;
    localparam logic [1:0] ST_SAT   = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;
    localparam logic [1:0] ST_UNDEF = 2'd3;

    // Input word.
    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [WORD_W-1:0] a_re;
        logic signed [WORD_W-1:0] a_im;
        logic signed [WORD_W-1:0] b_re;
        logic signed [WORD_W-1:0] b_im;
    } t_in;

    // Result word.
    typedef struct packed {
        logic signed [WORD_W-1:0] res_re;
        logic signed [WORD_W-1:0] res_im;
        logic                     greater;
        logic                     equal;
        logic [1:0]               status;
    } t_out;

    // Saturated value with its overflow flag.
    typedef struct packed {
        logic signed [WORD_W-1:0] val;
        logic                     sat;
    } t_clamp;

    // How the final stage forms the result.
    typedef enum logic [2:0] {
        FIN_DIRECT,
        FIN_MUL,
        FIN_QUO_RE,
        FIN_QUO_BOTH,
        FIN_REM
    } t_fin;

    // Item information that rides alongside the divider.
    typedef struct packed {
        logic signed [WORD_W-1:0] re;
        logic signed [WORD_W-1:0] im;
        logic [1:0]               status;
        logic                     greater;
        logic                     equal;
        logic                     neg_re;
        logic                     neg_im;
        t_fin                     fin;
    } t_side;

endpackage

@@ hdl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, remainder, negate and compare on signed
// fixed-point complex words, with saturation and lexicographic compare flags.
// ----------------------------------------------------------------------------
// The unit takes one word per clock while the output is not stalled and
// returns one result word per input word, in order.
// The divider loads its operands in one stage and then resolves one
// quotient bit per stage over 32 stages; four front stages clamp the
// operands, form the products, form the sums and prepare the divider,
// and one output register follows.
// A stall on the output holds the whole pipeline.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  cau_pkg::t_in   i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output cau_pkg::t_out  o_out
);

    localparam int EFF_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam logic signed [64:0] MAXV_W    = (65'sd1 <<< (EFF_W - 1)) - 65'sd1;
    localparam logic signed [31:0] MAXV      = MAXV_W[31:0];
    localparam logic signed [64:0] FRAC_MASK = (65'sd1 <<< FRAC_BITS) - 65'sd1;
    localparam int NUM_W = cau_pkg::PROD_W + FRAC_BITS;
    localparam int LAST  = cau_pkg::DIV_STEPS;

    // Sign extension of a field to the wide working width.
    function automatic logic signed [64:0] sx(input logic signed [31:0] x);
        return {{33{x[31]}}, x};
    endfunction

    // Magnitude of a wide signed value known to be below 2^64.
    function automatic logic [63:0] mag(input logic signed [64:0] v);
        logic signed [64:0] n;
        n = -v;
        return v[64] ? n[63:0] : v[63:0];
    endfunction

    // Saturate to the symmetric range.
    function automatic cau_pkg::t_clamp fx_clamp(input logic signed [64:0] v);
        cau_pkg::t_clamp c;
        c.sat = 1'b0;
        c.val = v[31:0];
        if (v > MAXV_W) begin
            c.val = MAXV;
            c.sat = 1'b1;
        end else if (v < -MAXV_W) begin
            c.val = -MAXV;
            c.sat = 1'b1;
        end
        return c;
    endfunction

    logic en;

    // A full output register that is stalled holds every stage.
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ------------------------------------------------------------------
    // Stage 1: clamp the operands.
    // ------------------------------------------------------------------
    logic                r_s1_v;
    logic [2:0]          r_s1_op;
    logic signed [31:0]  r_s1_ar, r_s1_ai, r_s1_br, r_s1_bi;
    cau_pkg::t_clamp     c_ar, c_ai, c_br, c_bi;

    assign c_ar = fx_clamp(sx(i_in.a_re));
    assign c_ai = fx_clamp(sx(i_in.a_im));
    assign c_br = fx_clamp(sx(i_in.b_re));
    assign c_bi = fx_clamp(sx(i_in.b_im));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op <= i_in.opcode;
            r_s1_ar <= c_ar.val;
            r_s1_ai <= c_ai.val;
            r_s1_br <= c_br.val;
            r_s1_bi <= c_bi.val;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products, compare flags and the simple operations.
    // ------------------------------------------------------------------
    logic                r_s2_v;
    logic [2:0]          r_s2_op;
    logic signed [31:0]  r_s2_ar, r_s2_ai, r_s2_br, r_s2_bi;
    logic signed [63:0]  r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    logic                r_s2_gt, r_s2_eq;
    logic signed [31:0]  r_s2_re, r_s2_im;
    logic [1:0]          r_s2_st;
    logic signed [31:0]  n_s2_re, n_s2_im;
    logic [1:0]          n_s2_st;
    cau_pkg::t_clamp     c_re, c_im;

    always_comb begin
        c_re    = '0;
        c_im    = '0;
        n_s2_re = '0;
        n_s2_im = '0;
        n_s2_st = cau_pkg::ST_EXACT;
        case (r_s1_op)
            cau_pkg::OP_ADD: begin
                c_re    = fx_clamp(sx(r_s1_ar) + sx(r_s1_br));
                c_im    = fx_clamp(sx(r_s1_ai) + sx(r_s1_bi));
                n_s2_re = c_re.val;
                n_s2_im = c_im.val;
                n_s2_st = (c_re.sat || c_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_EXACT;
            end
            cau_pkg::OP_SUB: begin
                c_re    = fx_clamp(sx(r_s1_ar) - sx(r_s1_br));
                c_im    = fx_clamp(sx(r_s1_ai) - sx(r_s1_bi));
                n_s2_re = c_re.val;
                n_s2_im = c_im.val;
                n_s2_st = (c_re.sat || c_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_EXACT;
            end
            cau_pkg::OP_NEG: begin
                n_s2_re = -r_s1_ar;
                n_s2_im = -r_s1_ai;
            end
            default: begin
                n_s2_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_op <= r_s1_op;
            r_s2_ar <= r_s1_ar;
            r_s2_ai <= r_s1_ai;
            r_s2_br <= r_s1_br;
            r_s2_bi <= r_s1_bi;
            r_p_rr  <= r_s1_ar * r_s1_br;
            r_p_ii  <= r_s1_ai * r_s1_bi;
            r_p_ri  <= r_s1_ar * r_s1_bi;
            r_p_ir  <= r_s1_ai * r_s1_br;
            r_p_bb  <= r_s1_br * r_s1_br;
            r_p_cc  <= r_s1_bi * r_s1_bi;
            r_s2_gt <= (r_s1_ar > r_s1_br) || ((r_s1_ar == r_s1_br) && (r_s1_ai > r_s1_bi));
            r_s2_eq <= (r_s1_ar == r_s1_br) && (r_s1_ai == r_s1_bi);
            r_s2_re <= n_s2_re;
            r_s2_im <= n_s2_im;
            r_s2_st <= n_s2_st;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: product sums and the divide and remainder special cases.
    // ------------------------------------------------------------------
    logic                r_s3_v;
    logic signed [31:0]  r_s3_ar, r_s3_br;
    logic signed [64:0]  r_mr, r_mi, r_nr, r_ni;
    logic [63:0]         r_den;
    logic                r_s3_gt, r_s3_eq;
    logic signed [31:0]  r_s3_re, r_s3_im;
    logic [1:0]          r_s3_st;
    cau_pkg::t_fin       r_s3_fin;
    logic signed [31:0]  n_s3_re, n_s3_im;
    logic [1:0]          n_s3_st;
    cau_pkg::t_fin       n_s3_fin;
    logic                ai0, bi0, br0, ar_int, br_int;

    assign ai0    = (r_s2_ai == '0);
    assign bi0    = (r_s2_bi == '0);
    assign br0    = (r_s2_br == '0);
    assign ar_int = ((sx(r_s2_ar) & FRAC_MASK) == '0);
    assign br_int = ((sx(r_s2_br) & FRAC_MASK) == '0);

    always_comb begin
        n_s3_re  = r_s2_re;
        n_s3_im  = r_s2_im;
        n_s3_st  = r_s2_st;
        n_s3_fin = cau_pkg::FIN_DIRECT;
        case (r_s2_op)
            cau_pkg::OP_MUL: begin
                n_s3_fin = cau_pkg::FIN_MUL;
            end
            cau_pkg::OP_DIV: begin
                if (r_s2_br == MAXV && r_s2_ar != MAXV) begin
                    // Division by infinity.
                    n_s3_st = cau_pkg::ST_EXACT;
                end else if (ai0 && bi0 && !br0) begin
                    n_s3_fin = cau_pkg::FIN_QUO_RE;
                end else if (br0 && bi0) begin
                    // Division by zero goes to infinity unless a is positive infinity.
                    if (r_s2_ar != MAXV) begin
                        n_s3_re = (r_s2_ar > 0) ? MAXV : -MAXV;
                        n_s3_st = cau_pkg::ST_DIV0;
                    end else begin
                        n_s3_st = cau_pkg::ST_UNDEF;
                    end
                end else begin
                    n_s3_fin = cau_pkg::FIN_QUO_BOTH;
                end
            end
            cau_pkg::OP_REM: begin
                if (ai0 && bi0 && ar_int && br_int) begin
                    if (!br0) begin
                        n_s3_fin = cau_pkg::FIN_REM;
                    end else begin
                        n_s3_st = cau_pkg::ST_UNDEF;
                    end
                end
            end
            default: begin
                n_s3_fin = cau_pkg::FIN_DIRECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_ar  <= r_s2_ar;
            r_s3_br  <= r_s2_br;
            r_mr     <= {r_p_rr[63], r_p_rr} - {r_p_ii[63], r_p_ii};
            r_mi     <= {r_p_ri[63], r_p_ri} + {r_p_ir[63], r_p_ir};
            r_nr     <= {r_p_rr[63], r_p_rr} + {r_p_ii[63], r_p_ii};
            r_ni     <= {r_p_ir[63], r_p_ir} - {r_p_ri[63], r_p_ri};
            r_den    <= r_p_bb + r_p_cc;
            r_s3_gt  <= r_s2_gt;
            r_s3_eq  <= r_s2_eq;
            r_s3_re  <= n_s3_re;
            r_s3_im  <= n_s3_im;
            r_s3_st  <= n_s3_st;
            r_s3_fin <= n_s3_fin;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale the product and set up the two divider lanes.
    // ------------------------------------------------------------------
    logic                r_s4_v;
    logic [NUM_W-1:0]    r_num_re, r_num_im;
    logic [63:0]         r_den_re, r_den_im;
    cau_pkg::t_side      r_s4_side;
    logic [NUM_W-1:0]    n_num_re, n_num_im;
    logic [63:0]         n_den_re, n_den_im;
    cau_pkg::t_side      n_s4_side;
    logic signed [64:0]  t_mr, t_mi;
    cau_pkg::t_clamp     c_mr, c_mi;

    // Products are scaled down by the fraction bits, rounding toward zero.
    assign t_mr = (r_mr + (r_mr[64] ? FRAC_MASK : 65'sd0)) >>> FRAC_BITS;
    assign t_mi = (r_mi + (r_mi[64] ? FRAC_MASK : 65'sd0)) >>> FRAC_BITS;
    assign c_mr = fx_clamp(t_mr);
    assign c_mi = fx_clamp(t_mi);

    always_comb begin
        n_num_re          = '0;
        n_num_im          = '0;
        n_den_re          = '0;
        n_den_im          = '0;
        n_s4_side.re      = r_s3_re;
        n_s4_side.im      = r_s3_im;
        n_s4_side.status  = r_s3_st;
        n_s4_side.greater = r_s3_gt;
        n_s4_side.equal   = r_s3_eq;
        n_s4_side.neg_re  = 1'b0;
        n_s4_side.neg_im  = 1'b0;
        n_s4_side.fin     = r_s3_fin;
        unique case (r_s3_fin)
            cau_pkg::FIN_MUL: begin
                n_s4_side.re     = c_mr.val;
                n_s4_side.im     = c_mi.val;
                n_s4_side.status = (c_mr.sat || c_mi.sat) ? cau_pkg::ST_SAT
                                                           : cau_pkg::ST_EXACT;
                n_s4_side.fin    = cau_pkg::FIN_DIRECT;
            end
            cau_pkg::FIN_QUO_RE: begin
                n_num_re         = NUM_W'(mag(sx(r_s3_ar))) << FRAC_BITS;
                n_den_re         = mag(sx(r_s3_br));
                n_s4_side.neg_re = r_s3_ar[31] ^ r_s3_br[31];
            end
            cau_pkg::FIN_QUO_BOTH: begin
                n_num_re         = NUM_W'(mag(r_nr)) << FRAC_BITS;
                n_num_im         = NUM_W'(mag(r_ni)) << FRAC_BITS;
                n_den_re         = r_den;
                n_den_im         = r_den;
                n_s4_side.neg_re = r_nr[64];
                n_s4_side.neg_im = r_ni[64];
            end
            cau_pkg::FIN_REM: begin
                // Both operands are whole numbers, so the remainder of the
                // fixed-point words is the scaled integer remainder.
                n_num_re         = NUM_W'(mag(sx(r_s3_ar)));
                n_den_re         = mag(sx(r_s3_br));
                n_s4_side.neg_re = r_s3_ar[31];
            end
            default: begin
                n_num_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_re  <= n_num_re;
            r_num_im  <= n_num_im;
            r_den_re  <= n_den_re;
            r_den_im  <= n_den_im;
            r_s4_side <= n_s4_side;
        end
    end

    // ------------------------------------------------------------------
    // Divider lanes and the item information that travels beside them.
    // ------------------------------------------------------------------
    logic [31:0]         quo_re, quo_im;
    logic                ovf_re, ovf_im;
    logic [63:0]         rem_re;
    logic                r_sd_v [0:LAST];
    cau_pkg::t_side      r_sd   [0:LAST];

    cau_div #(
        .NUM_W (NUM_W),
        .QUO_W (cau_pkg::DIV_STEPS),
        .DEN_W (cau_pkg::PROD_W)
    ) u_div_re (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_re),
        .i_den (r_den_re),
        .o_quo (quo_re),
        .o_ovf (ovf_re),
        .o_rem (rem_re)
    );

    cau_div #(
        .NUM_W (NUM_W),
        .QUO_W (cau_pkg::DIV_STEPS),
        .DEN_W (cau_pkg::PROD_W)
    ) u_div_im (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_im),
        .i_den (r_den_im),
        .o_quo (quo_im),
        .o_ovf (ovf_im),
        .o_rem ()
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_s4_side;
            for (int k = 1; k <= LAST; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            for (int k = 0; k <= LAST; k++) begin
                r_sd_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_s1_v    <= i_valid;
            r_s2_v    <= r_s1_v;
            r_s3_v    <= r_s2_v;
            r_s4_v    <= r_s3_v;
            r_sd_v[0] <= r_s4_v;
            for (int k = 1; k <= LAST; k++) begin
                r_sd_v[k] <= r_sd_v[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: saturate and sign the quotients, pick the result.
    // ------------------------------------------------------------------
    cau_pkg::t_side      fs;
    logic                sat_re, sat_im;
    logic signed [31:0]  mag_re, mag_im, val_re, val_im, rem_v;
    cau_pkg::t_out       n_out;
    cau_pkg::t_out       r_out;
    logic                r_out_v;

    assign fs     = r_sd[LAST];
    assign sat_re = ovf_re || (quo_re > 32'(MAXV));
    assign sat_im = ovf_im || (quo_im > 32'(MAXV));
    assign mag_re = sat_re ? MAXV : quo_re;
    assign mag_im = sat_im ? MAXV : quo_im;
    assign val_re = fs.neg_re ? -mag_re : mag_re;
    assign val_im = fs.neg_im ? -mag_im : mag_im;
    assign rem_v  = fs.neg_re ? -rem_re[31:0] : rem_re[31:0];

    always_comb begin
        n_out.greater = fs.greater;
        n_out.equal   = fs.equal;
        n_out.res_re  = fs.re;
        n_out.res_im  = fs.im;
        n_out.status  = fs.status;
        unique case (fs.fin)
            cau_pkg::FIN_QUO_RE: begin
                n_out.res_re = val_re;
                n_out.res_im = '0;
                n_out.status = sat_re ? cau_pkg::ST_SAT : cau_pkg::ST_EXACT;
            end
            cau_pkg::FIN_QUO_BOTH: begin
                n_out.res_re = val_re;
                n_out.res_im = val_im;
                n_out.status = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_EXACT;
            end
            cau_pkg::FIN_REM: begin
                n_out.res_re = rem_v;
                n_out.res_im = '0;
                n_out.status = cau_pkg::ST_EXACT;
            end
            default: begin
                n_out.res_re = fs.re;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_sd_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_out   = r_out;

endmodule

@@ hdl/cau_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned divide producing one quotient bit per stage, with an overflow
// flag for quotients that do not fit and the final remainder.
// ----------------------------------------------------------------------------
module cau_div #(
    parameter int NUM_W = 80,
    parameter int QUO_W = 32,
    parameter int DEN_W = 64
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_ovf,
    output logic [DEN_W-1:0] o_rem
);

    localparam int HI_W = NUM_W - QUO_W;

    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_lo  [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_ovf [0:QUO_W];
    logic [HI_W-1:0]  hi;

    // The upper part of the dividend must stay below the divisor, or the
    // quotient needs more than QUO_W bits.
    assign hi = i_num[NUM_W-1:QUO_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DEN_W'(hi);
            r_ovf[0] <= (DEN_W'(hi) >= i_den);
            r_lo[0]  <= i_num[QUO_W-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // One trial subtraction per stage, most significant quotient bit first.
    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {r_rem[k-1], r_lo[k-1][QUO_W-k]};
        assign diff  = trial - {1'b0, r_den[k-1]};
        assign ge    = (trial >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], ge};
                r_lo[k]  <= r_lo[k-1];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_ovf = r_ovf[QUO_W];
    assign o_rem = r_rem[QUO_W];

endmodule

@@ hdl/cau_chk.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input cau_pkg::t_in  i_in,
    input logic          o_valid,
    input logic          i_stall,
    input cau_pkg::t_out o_out
);

    // A stalled result word stays offered.
    `ASSERT_CLK(a_hold_valid, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid)

    // A word is never both greater and equal.
    `ASSERT_NEVER(a_flags_excl, i_clk, i_rst_n, o_valid && o_out.greater && o_out.equal)

    // Saturation never lets the most negative code through.
    `ASSERT_NEVER(a_no_minint, i_clk, i_rst_n, o_valid && (o_out.res_re == 32'h8000_0000 || o_out.res_im == 32'h8000_0000))

    // Division by zero yields a real infinity.
    `ASSERT_CLK(a_div0_shape, i_clk, i_rst_n, (o_valid && o_out.status == cau_pkg::ST_DIV0) |-> (o_out.res_im == '0 && o_out.res_re != '0))

    // An undefined result is zero.
    `ASSERT_CLK(a_undef_zero, i_clk, i_rst_n, (o_valid && o_out.status == cau_pkg::ST_UNDEF) |-> (o_out.res_re == '0 && o_out.res_im == '0))

endmodule

bind complex_arithmetic_unit cau_chk u_cau_chk (.*);
